// ----- hw/rtl/btsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table speed lookup: shared package
// Table sizing, field widths, command and status codes, and the record types
// passed between the controller and the point memory.
// ----------------------------------------------------------------------------
package btsl_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned POS_W     = 24;
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned ENTRIES_W = 9;

    localparam int unsigned MIN_LOOKUP_POINTS = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_ORDER = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [SPEED_W-1:0] speed;
    } point_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        point_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ----- hw/rtl/breakpoint_table_speed_lookup_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table speed lookup unit
// Sorted table of (position, speed limit) breakpoints with append, clear and
// lower-bound lookup requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one result. Append,
// clear and unused command codes finish in the cycle they are accepted, so
// they run at one request per cycle while the result side keeps up. A lookup
// holds the input while it runs its binary search probes over the held points
// and then reads the chosen point; the bound is the single read port of the
// point memory, which serves one probe per cycle. Appends are checked against
// the last stored position, and the memory is never read outside the held
// range, so it needs no clearing after reset. Results wait in an output
// register, and a new request is taken while an earlier result is still
// waiting.
// ----------------------------------------------------------------------------
module breakpoint_table_speed_lookup_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [btsl_pkg::CMD_W-1:0]        s_command,
    input  logic [btsl_pkg::POS_W-1:0]        s_position,
    input  logic [btsl_pkg::SPEED_W-1:0]      s_speed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [btsl_pkg::SPEED_W-1:0]      m_limit,
    output logic [btsl_pkg::STATUS_W-1:0]     m_status,
    output logic [btsl_pkg::ENTRIES_W-1:0]    m_entries
);
    import btsl_pkg::*;

    mem_req_t mem_req;
    point_t   rd_data;

    btsl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_position (s_position),
        .s_speed    (s_speed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_limit    (m_limit),
        .m_status   (m_status),
        .m_entries  (m_entries),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    btsl_point_mem u_point_mem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ----- hw/rtl/btsl_point_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint point memory
// Single-port-write, single-port-read synchronous memory holding one
// (position, speed) record per entry, with registered read data.
// ----------------------------------------------------------------------------
module btsl_point_mem (
    input  logic              aclk,
    input  btsl_pkg::mem_req_t mem_req,
    output btsl_pkg::point_t   rd_data
);
    import btsl_pkg::*;

    point_t mem [TABLE_DEPTH];
    point_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/btsl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table controller
// Decodes requests, keeps the point count, runs the lower-bound binary search
// against the point memory and holds the result in an output register.
// ----------------------------------------------------------------------------
module btsl_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [btsl_pkg::CMD_W-1:0]        s_command,
    input  logic [btsl_pkg::POS_W-1:0]        s_position,
    input  logic [btsl_pkg::SPEED_W-1:0]      s_speed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [btsl_pkg::SPEED_W-1:0]      m_limit,
    output logic [btsl_pkg::STATUS_W-1:0]     m_status,
    output logic [btsl_pkg::ENTRIES_W-1:0]    m_entries,
    output btsl_pkg::mem_req_t                mem_req,
    input  btsl_pkg::point_t                  rd_data
);
    import btsl_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;

    logic [POS_W-1:0]     last_pos_reg, last_pos_next;
    logic [POS_W-1:0]     query_reg, query_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic [SPEED_W-1:0]   res_limit_reg, res_limit_next;
    status_t              res_status_reg, res_status_next;
    logic [SPEED_W-1:0]   m_limit_reg, m_limit_next;
    status_t              m_status_reg, m_status_next;
    logic [ENTRIES_W-1:0] m_entries_reg, m_entries_next;

    logic                 out_free;
    logic                 finish;
    logic [SPEED_W-1:0]   res_limit;
    status_t              res_status;
    logic [CNT_W-1:0]     lo_n, hi_n, last_idx;
    logic [CNT_W:0]       mid_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_pos_reg   <= last_pos_next;
        query_reg      <= query_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_limit_reg  <= res_limit_next;
        res_status_reg <= res_status_next;
        m_limit_reg    <= m_limit_next;
        m_status_reg   <= m_status_next;
        m_entries_reg  <= m_entries_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_pos_next   = last_pos_reg;
        query_next      = query_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_limit_next  = res_limit_reg;
        res_status_next = res_status_reg;
        m_limit_next    = m_limit_reg;
        m_status_next   = m_status_reg;
        m_entries_next  = m_entries_reg;

        out_free     = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == S_IDLE);

        finish     = 1'b0;
        res_limit  = '0;
        res_status = ST_OK;
        lo_n       = lo_reg;
        hi_n       = hi_reg;
        mid_sum    = '0;
        last_idx   = count_reg - CNT_W'(1);

        mem_req         = '0;
        mem_req.wr_addr = count_reg[IDX_W-1:0];
        mem_req.wr_data = '{position: s_position, speed: s_speed};
        mem_req.rd_addr = mid_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        CMD_APPEND: begin
                            finish = 1'b1;
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                res_status = ST_FULL;
                            end else if (count_reg != '0 && s_position < last_pos_reg) begin
                                res_status = ST_ORDER;
                            end else begin
                                mem_req.wr_en = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                last_pos_next = s_position;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (count_reg < CNT_W'(MIN_LOOKUP_POINTS)) begin
                                finish     = 1'b1;
                                res_status = ST_FEW;
                            end else begin
                                // The first probe is the middle of the held points.
                                query_next      = s_position;
                                lo_next         = '0;
                                hi_next         = count_reg;
                                mid_next        = IDX_W'(count_reg >> 1);
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = mid_next;
                                state_next      = S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            finish     = 1'b1;
                            count_next = '0;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // The read data belongs to mid_reg; narrow the interval and
                // issue the next probe in the same cycle.
                if (rd_data.position < query_reg) begin
                    lo_n = CNT_W'(mid_reg) + CNT_W'(1);
                end else begin
                    hi_n = CNT_W'(mid_reg);
                end
                lo_next = lo_n;
                hi_next = hi_n;
                mem_req.rd_en = 1'b1;
                if (lo_n < hi_n) begin
                    mid_sum         = {1'b0, lo_n} + {1'b0, hi_n};
                    mid_next        = IDX_W'(mid_sum >> 1);
                    mem_req.rd_addr = mid_next;
                end else begin
                    // A query past the last point takes the last point.
                    if (lo_n >= count_reg) begin
                        mem_req.rd_addr = last_idx[IDX_W-1:0];
                    end else begin
                        mem_req.rd_addr = lo_n[IDX_W-1:0];
                    end
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                finish    = 1'b1;
                res_limit = rd_data.speed;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_limit_next   = res_limit_reg;
                    m_status_next  = res_status_reg;
                    m_entries_next = ENTRIES_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
        endcase

        // A finished request goes straight to the output register when it is
        // free, otherwise it is parked until the previous result is taken.
        if (finish) begin
            if (out_free) begin
                m_valid_next   = 1'b1;
                m_limit_next   = res_limit;
                m_status_next  = res_status;
                m_entries_next = ENTRIES_W'(count_next);
                state_next     = S_IDLE;
            end else begin
                res_limit_next  = res_limit;
                res_status_next = res_status;
                state_next      = S_DONE;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_limit   = m_limit_reg;
    assign m_status  = m_status_reg;
    assign m_entries = m_entries_reg;

endmodule

// ----- hw/rtl/btsl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table speed lookup: port checker
// Watches the top-level ports for result consistency and output handshake.
// ----------------------------------------------------------------------------
module btsl_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [btsl_pkg::SPEED_W-1:0]      m_limit,
    input logic [btsl_pkg::STATUS_W-1:0]     m_status,
    input logic [btsl_pkg::ENTRIES_W-1:0]    m_entries
);
    import btsl_pkg::*;

    // A held result must not change until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_limit) && $stable(m_status)
            && $stable(m_entries))
        else $error("result changed while stalled");

    // Too few points can only be reported with fewer than two entries.
    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FEW |->
            m_limit == '0 && m_entries < ENTRIES_W'(MIN_LOOKUP_POINTS))
        else $error("too-few status with a usable table");

    // A full-table refusal reports the full count.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |->
            m_limit == '0 && m_entries == ENTRIES_W'(TABLE_DEPTH))
        else $error("full status with a table that is not full");

    // Refused appends carry no speed.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ORDER |-> m_limit == '0 && m_entries != '0)
        else $error("out-of-order status with a speed or an empty table");

endmodule

bind breakpoint_table_speed_lookup_unit btsl_checker u_btsl_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the breakpoint table speed lookup unit
// Drives append, lookup, clear and unused-code requests into the unit and
// predicts every result with its own copy of the breakpoint table. Each
// result is checked field by field against the oldest prediction. Directed
// tests cover short tables, order violations, lookup bounds and a full table.
// Random tables of mostly small sizes then run under three idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import btsl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int unsigned      POS_MAX      = 24'hFF_FFFF;
    localparam int unsigned      CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned      DRAIN_CYCLES = 32;
    localparam int               PEND_DEPTH   = 64;

    typedef struct {
        logic [SPEED_W-1:0]   limit;
        status_t              status;
        logic [ENTRIES_W-1:0] entries;
    } speed_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    logic [POS_W-1:0]     s_position;
    logic [SPEED_W-1:0]   s_speed;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SPEED_W-1:0]   m_limit;
    logic [STATUS_W-1:0]  m_status;
    logic [ENTRIES_W-1:0] m_entries;

    // Breakpoints as the unit should hold them.
    bit [POS_W-1:0]   held_pos   [TABLE_DEPTH];
    bit [SPEED_W-1:0] held_speed [TABLE_DEPTH];
    int               held_count = 0;

    // Predicted results in request order, as a ring with running indexes.
    speed_result_t pending_results [PEND_DEPTH];
    int            pend_wr = 0;
    int            pend_rd = 0;
    speed_result_t oldest;
    int            send_idle_pct = 23;
    int            recv_idle_pct = 81;
    int            requests_sent = 0;
    int            results_seen  = 0;
    int            status_tally [4] = '{0, 0, 0, 0};
    int            errors        = 0;
    int            cycle_count   = 0;

    breakpoint_table_speed_lookup_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_position (s_position),
        .s_speed    (s_speed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_limit    (m_limit),
        .m_status   (m_status),
        .m_entries  (m_entries)
    );

    always #5 aclk = ~aclk;

    // Applies one request to the table copy and returns the result it gives.
    function automatic speed_result_t apply_request(logic [CMD_W-1:0] cmd,
                                                    logic [POS_W-1:0] pos,
                                                    logic [SPEED_W-1:0] spd);
        speed_result_t r;
        int lo;
        int hi;
        int mid;
        r.limit  = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (held_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (held_count > 0 && pos < held_pos[held_count-1]) begin
                    r.status = ST_ORDER;
                end else begin
                    held_pos[held_count]   = pos;
                    held_speed[held_count] = spd;
                    held_count++;
                end
            end
            CMD_LOOKUP: begin
                if (held_count < MIN_LOOKUP_POINTS) begin
                    r.status = ST_FEW;
                end else begin
                    // Lower bound: first point at or above the query.
                    lo = 0;
                    hi = held_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (held_pos[mid] < pos) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo >= held_count) lo = held_count - 1;
                    r.limit = held_speed[lo];
                end
            end
            CMD_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        r.entries = ENTRIES_W'(held_count);
        return r;
    endfunction

    // Picks a query near the held points, at the extremes, or anywhere.
    function automatic logic [POS_W-1:0] pick_query();
        int k;
        logic [POS_W-1:0] q;
        k = (held_count > 0) ? $urandom_range(held_count - 1) : 0;
        case ($urandom_range(5))
            0: q = POS_W'($urandom);
            1: q = held_pos[k] - 1'b1;
            2: q = held_pos[k] + 1'b1;
            3: q = $urandom_range(1) ? POS_W'(0) : POS_W'(POS_MAX);
            default: q = held_pos[k];
        endcase
        return q;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [SPEED_W-1:0] spd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_command  = cmd;
        s_position = pos;
        s_speed    = spd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results[pend_wr % PEND_DEPTH] = apply_request(cmd, pos, spd);
        pend_wr++;
        requests_sent++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_tally[m_status]++;
            if (pend_wr == pend_rd) begin
                errors++;
                $display("%0t: result without a pending request: expected none, actual %0d %0d %0d",
                         $time, m_limit, m_status, m_entries);
            end else begin
                oldest = pending_results[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("limit", oldest.limit, m_limit);
                check_field("status", oldest.status, m_status);
                check_field("entries", oldest.entries, m_entries);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Lookups on empty and one-point tables, equal and descending appends.
    task automatic test_short_tables();
        send_request(CMD_LOOKUP, 24'd0, 16'd0);
        send_request(CMD_APPEND, 24'd0, 16'hFFFF);
        send_request(CMD_LOOKUP, 24'd5, 16'd0);
        send_request(CMD_APPEND, 24'd0, 16'd0);
        send_request(CMD_APPEND, 24'd100, 16'd1234);
        send_request(CMD_APPEND, 24'd50, 16'd7);
    endtask

    // Queries on a point, between points and above the last.
    task automatic test_lookup_bounds();
        send_request(CMD_LOOKUP, 24'd200, 16'd0);
        send_request(CMD_LOOKUP, 24'd0, 16'd0);
        send_request(CMD_LOOKUP, 24'd1, 16'd0);
        send_request(CMD_APPEND, POS_W'(POS_MAX), 16'h8000);
        send_request(CMD_LOOKUP, 24'd101, 16'd0);
        send_request(CMD_LOOKUP, POS_W'(POS_MAX), 16'd0);
    endtask

    task automatic test_unused_and_clear();
        send_request(CMD_UNUSED, POS_W'(POS_MAX), 16'hFFFF);
        send_request(CMD_CLEAR, POS_W'(POS_MAX), 16'hFFFF);
        send_request(CMD_LOOKUP, 24'd0, 16'd0);
        send_request(CMD_APPEND, 24'h80_0000, 16'd1);
        send_request(CMD_APPEND, 24'h7F_FFFF, 16'd2);
        send_request(CMD_APPEND, 24'hFF_FFFF, 16'd2);
        send_request(CMD_LOOKUP, 24'd1, 16'd0);
        send_request(CMD_CLEAR, 24'd0, 16'd0);
    endtask

    // Fill every slot, then appends must be refused as full, even descending.
    task automatic test_full_table();
        send_idle_pct = 23;
        recv_idle_pct = 81;
        send_request(CMD_CLEAR, 24'd0, 16'd0);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_request(CMD_APPEND, POS_W'(i * 65793), SPEED_W'($urandom));
        end
        send_request(CMD_APPEND, POS_W'(POS_MAX), 16'd9);
        send_request(CMD_APPEND, 24'd0, 16'd9);
        for (int i = 0; i < 8; i++) begin
            send_request(CMD_LOOKUP, pick_query(), 16'd0);
        end
        send_request(CMD_CLEAR, 24'd0, 16'd0);
    endtask

    // Ascending tables with random content, some order violations and noise,
    // followed by a burst of lookups. Most tables are small.
    task automatic run_random_tables(input int target, input int send_pct, input int recv_pct);
        int stop_at;
        int n_points;
        int step_max;
        int roll;
        int prev;
        int p;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at) begin
            if ($urandom_range(9) != 0) begin
                send_request(CMD_CLEAR, POS_W'($urandom), SPEED_W'($urandom));
            end
            roll = $urandom_range(99);
            if (roll < 70) n_points = $urandom_range(6);
            else if (roll < 98) n_points = $urandom_range(40, 7);
            else n_points = TABLE_DEPTH + $urandom_range(3);
            case ($urandom_range(3))
                0: step_max = 0;
                1: step_max = 3;
                2: step_max = 1000;
                default: step_max = 1 << 20;
            endcase
            prev = (held_count > 0) ? held_pos[held_count-1] : $urandom_range(POS_MAX);
            for (int i = 0; i < n_points; i++) begin
                roll = $urandom_range(99);
                if (roll < 8 && prev > 0) begin
                    send_request(CMD_APPEND, POS_W'($urandom_range(prev - 1)),
                                 SPEED_W'($urandom));
                end else if (roll < 14) begin
                    send_request(CMD_LOOKUP, pick_query(), SPEED_W'($urandom));
                end else if (roll < 16) begin
                    send_request(CMD_UNUSED, POS_W'($urandom), SPEED_W'($urandom));
                end else begin
                    p = prev + $urandom_range(step_max);
                    if (p > POS_MAX) p = POS_MAX;
                    send_request(CMD_APPEND, POS_W'(p), SPEED_W'($urandom));
                    prev = p;
                end
            end
            repeat ($urandom_range(12, 1)) begin
                send_request(CMD_LOOKUP, pick_query(), SPEED_W'($urandom));
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_command  = CMD_APPEND;
        s_position = '0;
        s_speed    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_short_tables();
        test_lookup_bounds();
        test_unused_and_clear();
        test_full_table();
        run_random_tables(700, 23, 81);
        run_random_tables(700, 81, 23);
        run_random_tables(600, 0, 0);

        @(negedge aclk);
        s_valid = 1'b0;
        while (pend_wr != pend_rd) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results in %0d cycles.",
                 requests_sent, results_seen, cycle_count);
        $display("Status counts: ok %0d, too few %0d, out of order %0d, full %0d.",
                 status_tally[ST_OK], status_tally[ST_FEW], status_tally[ST_ORDER],
                 status_tally[ST_FULL]);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
